>>> rtl/dvid_pkg.sv
// ----------------------------------------------------------------------------
// dvid_pkg: shared types and constants for the delta varint list decoder
// Word layouts, decoder state and varint limits.
// ----------------------------------------------------------------------------
package dvid_pkg;

  localparam int unsigned MAX_VARINT_BYTES = 5;
  localparam int unsigned BYTES_W          = 3;

  localparam logic [31:0] S32_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN    = 32'h8000_0000;
  localparam logic [7:0]  LEAD_BYTE  = 8'h80;
  localparam logic [31:0] OVF_MASK   = 32'hFE00_0000;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       list_end;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        varint_accum;
    logic [BYTES_W-1:0] varint_bytes;
    logic [31:0]        running_value;
    logic               error_skip;
  } dec_state_t;

endpackage

>>> rtl/dvid_in_stage.sv
// ----------------------------------------------------------------------------
// dvid_in_stage: input register
// Captures one input word and holds it until the decode step takes it.
// ----------------------------------------------------------------------------
module dvid_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dvid_pkg::in_word_t in_data,
  output logic              s_valid,
  output dvid_pkg::in_word_t s_data,
  input  logic              s_take
);
  import dvid_pkg::*;

  assign in_ready = !s_valid || s_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (s_take) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_data <= in_data;
    end
  end

endmodule

>>> rtl/dvid_step.sv
// ----------------------------------------------------------------------------
// dvid_step: per-byte decode step
// Varint assembly, zigzag or sorted delta, running sum and error handling.
// ----------------------------------------------------------------------------
module dvid_step (
  input  dvid_pkg::in_word_t   word,
  input  logic                 sorted_mode,
  input  dvid_pkg::dec_state_t state,
  output dvid_pkg::dec_state_t state_next,
  output logic                 has_result,
  output dvid_pkg::out_word_t  result
);
  import dvid_pkg::*;

  logic [31:0]        acc_n;
  logic [BYTES_W-1:0] bytes_n;
  logic [31:0]        zz;
  logic [32:0]        delta;
  logic [32:0]        sum;
  logic               pre_fail;
  logic               cont;
  logic               cont_fail;
  logic               val_fail;
  logic               fail;

  always_comb begin
    acc_n     = {state.varint_accum[24:0], word.data_byte[6:0]};
    bytes_n   = state.varint_bytes + BYTES_W'(1);
    pre_fail  = ((state.varint_bytes == '0) && (word.data_byte == LEAD_BYTE)) ||
                ((state.varint_accum & OVF_MASK) != '0);
    cont      = word.data_byte[7];
    cont_fail = (bytes_n >= BYTES_W'(MAX_VARINT_BYTES)) || word.list_end;
    zz        = (acc_n >> 1) ^ {32{acc_n[0]}};
    delta     = sorted_mode ? {1'b0, acc_n} : {zz[31], zz};
    sum       = {state.running_value[31], state.running_value} + delta;
    val_fail  = (sorted_mode && (acc_n > S32_MAX)) || (sum[32] != sum[31]);
    fail      = pre_fail || (cont ? cont_fail : val_fail);

    state_next   = state;
    has_result   = 1'b0;
    result.value  = '0;
    result.status = STATUS_ERR;
    result.last   = word.list_end;

    if (state.error_skip) begin
      if (word.list_end) begin
        state_next = '0;
      end
    end else if (fail) begin
      has_result = 1'b1;
      if (word.list_end) begin
        state_next = '0;
      end else begin
        state_next.varint_accum = '0;
        state_next.varint_bytes = '0;
        state_next.error_skip   = 1'b1;
      end
    end else if (cont) begin
      state_next.varint_accum = acc_n;
      state_next.varint_bytes = bytes_n;
    end else begin
      has_result    = 1'b1;
      result.value  = sum[31:0];
      result.status = STATUS_OK;
      if (word.list_end) begin
        state_next = '0;
      end else begin
        state_next.varint_accum  = '0;
        state_next.varint_bytes  = '0;
        state_next.running_value = sum[31:0];
      end
    end
  end

endmodule

>>> rtl/delta_varint_int_list_decoder_top.sv
// ----------------------------------------------------------------------------
// delta_varint_int_list_decoder_top: delta varint integer list decoder
// Decodes a byte stream of base-128 varint deltas into int32 list elements.
// The accepted word is held in the input register; the decode step's result is
//   then loaded into the result register.
// Throughput: one byte per cycle unless stalled; combinational decode step.
// The input stalls only while a result word waits and the held word gives one.
// Reset clears the decoder state, both stage valid flags and sorted_mode.
// ----------------------------------------------------------------------------
module delta_varint_int_list_decoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  dvid_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dvid_pkg::out_word_t out_data
);
  import dvid_pkg::*;

  logic       sorted_mode;
  logic       s_valid;
  in_word_t   s_data;
  logic       s_take;
  dec_state_t state;
  dec_state_t state_next;
  logic       has_result;
  out_word_t  result;

  dvid_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_data   (s_data),
    .s_take   (s_take)
  );

  dvid_step u_step (
    .word        (s_data),
    .sorted_mode (sorted_mode),
    .state       (state),
    .state_next  (state_next),
    .has_result  (has_result),
    .result      (result)
  );

  assign s_take = s_valid && (!has_result || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_mode <= 1'b0;
    end else if (cfg_we) begin
      sorted_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s_take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_take && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take && has_result) begin
      out_data <= result;
    end
  end

  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    state.varint_bytes < BYTES_W'(MAX_VARINT_BYTES))
    else $error("varint byte count past limit");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    state.error_skip |-> (state.varint_accum == '0 && state.varint_bytes == '0))
    else $error("partial varint kept while dropping");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s_take && s_data.list_end |=> state == '0)
    else $error("state not cleared at list end");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_take |=> s_valid && $stable(s_data))
    else $error("input stage lost a word");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    s_take && has_result |=> out_valid)
    else $error("result dropped");

endmodule
